// File: hdl/ebmw_pkg.sv
// shared constants and helpers for the ext2 block map walker
package ebmw_pkg;

  localparam int DIRECT_POINTERS = 12;
  localparam int INODE_POINTERS  = 15;
  localparam int SLOT_W          = 4;
  localparam int WORD_W          = 32;
  localparam int INDEX_W         = 14;
  localparam int LOG_W           = 3;
  localparam int CMD_W           = 2;
  localparam int KIND_W          = 2;
  localparam int LEVEL_W         = 2;
  localparam int LIMIT_W         = 44;

  localparam logic [SLOT_W-1:0] SINGLE_SLOT = 4'd12;
  localparam logic [SLOT_W-1:0] DOUBLE_SLOT = 4'd13;
  localparam logic [SLOT_W-1:0] TRIPLE_SLOT = 4'd14;

  localparam logic [LOG_W-1:0] MAX_LOG_BLOCK = 3'd6;

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MAP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WORD = 2'd2;

  localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MAPPED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RANGE   = 2'd2;

  localparam logic [0:0] CFG_BLK_SIZE   = 1'b0;
  localparam logic [0:0] CFG_PART_START = 1'b1;

  // a block size code of 7 behaves as the largest legal one
  function automatic logic [LOG_W-1:0] eff_log(input logic [LOG_W-1:0] l);
    return (l > MAX_LOG_BLOCK) ? MAX_LOG_BLOCK : l;
  endfunction

  // input register contents handed to the step logic
  typedef struct packed {
    logic                valid;
    logic [CMD_W-1:0]    cmd;
    logic [SLOT_W-1:0]   slot;
    logic [WORD_W-1:0]   value;
  } item_t;

endpackage

// File: hdl/ebmw_ptr_file.sv
// inode block pointer registers: one write port, one indexed read, three fixed reads
module ebmw_ptr_file
  import ebmw_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [SLOT_W-1:0] wr_slot,
  input  logic [WORD_W-1:0] wr_data,
  input  logic [SLOT_W-1:0] rd_slot,
  output logic [WORD_W-1:0] rd_data,
  output logic [WORD_W-1:0] ptr_single,
  output logic [WORD_W-1:0] ptr_double,
  output logic [WORD_W-1:0] ptr_triple
);

  logic [WORD_W-1:0] ptrs [INODE_POINTERS];

  always_ff @(posedge clk) begin
    if (we && (wr_slot < SLOT_W'(INODE_POINTERS))) begin
      ptrs[wr_slot] <= wr_data;
    end
  end

  assign rd_data    = (rd_slot < SLOT_W'(INODE_POINTERS)) ? ptrs[rd_slot] : '0;
  assign ptr_single = ptrs[SINGLE_SLOT];
  assign ptr_double = ptrs[DOUBLE_SLOT];
  assign ptr_triple = ptrs[TRIPLE_SLOT];

endmodule

// File: hdl/ebmw_step.sv
// walk state, map decode and result register
module ebmw_step
  import ebmw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  item_t              item,
  input  logic [LOG_W-1:0]   blk_size_code,
  input  logic [WORD_W-1:0]  partition_start_sector,
  input  logic [WORD_W-1:0]  direct_ptr,
  input  logic [WORD_W-1:0]  ptr_single,
  input  logic [WORD_W-1:0]  ptr_double,
  input  logic [WORD_W-1:0]  ptr_triple,
  output logic               done,
  output logic [KIND_W-1:0]  kind,
  output logic [WORD_W-1:0]  block_num,
  output logic [INDEX_W-1:0] entry_index,
  output logic [WORD_W-1:0]  sector
);

  logic [LEVEL_W-1:0] walk_level, walk_level_next;
  logic [INDEX_W-1:0] middle_index, middle_index_next;
  logic [INDEX_W-1:0] low_index, low_index_next;

  logic               done_next;
  logic [KIND_W-1:0]  kind_next;
  logic [WORD_W-1:0]  blk_next;
  logic [INDEX_W-1:0] idx_next;
  logic               zero_sector;

  logic [LOG_W-1:0]   l_eff;
  logic [3:0]         sh;
  logic [5:0]         sh2, sh3;
  logic [LIMIT_W-1:0] n_wide, lim1, lim2, lim3;
  logic [WORD_W-1:0]  o1, o2, o2_sh, o_hi;
  logic [INDEX_W-1:0] emask;

  assign l_eff  = eff_log(blk_size_code);
  assign sh     = 4'd8 + 4'(l_eff);
  assign sh2    = {1'b0, sh, 1'b0};
  assign sh3    = sh2 + 6'(sh);
  assign n_wide = LIMIT_W'(item.value);
  assign lim1   = LIMIT_W'(DIRECT_POINTERS) + (LIMIT_W'(1) << sh);
  assign lim2   = lim1 + (LIMIT_W'(1) << sh2);
  assign lim3   = lim2 + (LIMIT_W'(1) << sh3);
  assign emask  = INDEX_W'((WORD_W'(1) << sh) - WORD_W'(1));
  // offsets into the double and triple ranges fit in 32 bits, as the logical block is a 32-bit value
  assign o1     = WORD_W'(n_wide - lim1);
  assign o2     = WORD_W'(n_wide - lim2);
  assign o2_sh  = o2 >> sh;
  assign o_hi   = o2 >> sh2;

  always_comb begin
    walk_level_next   = walk_level;
    middle_index_next = middle_index;
    low_index_next    = low_index;
    done_next         = 1'b0;
    kind_next         = KIND_REQUEST;
    blk_next          = '0;
    idx_next          = '0;
    zero_sector       = 1'b0;
    if (item.valid) begin
      case (item.cmd)
        CMD_MAP: begin
          done_next       = 1'b1;
          walk_level_next = '0;
          if (n_wide < LIMIT_W'(DIRECT_POINTERS)) begin
            kind_next = KIND_MAPPED;
            blk_next  = direct_ptr;
          end else if (n_wide < lim1) begin
            blk_next        = ptr_single;
            idx_next        = INDEX_W'(item.value - WORD_W'(DIRECT_POINTERS));
            walk_level_next = 2'd1;
          end else if (n_wide < lim2) begin
            blk_next        = ptr_double;
            idx_next        = INDEX_W'(o1 >> sh);
            low_index_next  = INDEX_W'(o1) & emask;
            walk_level_next = 2'd2;
          end else if (n_wide < lim3) begin
            blk_next          = ptr_triple;
            idx_next          = INDEX_W'(o_hi);
            low_index_next    = INDEX_W'(o2) & emask;
            middle_index_next = INDEX_W'(o2_sh) & emask;
            walk_level_next   = 2'd3;
          end else begin
            kind_next   = KIND_RANGE;
            zero_sector = 1'b1;
          end
        end
        CMD_WORD: begin
          blk_next = item.value;
          case (walk_level)
            2'd3: begin
              done_next       = 1'b1;
              idx_next        = middle_index;
              walk_level_next = 2'd2;
            end
            2'd2: begin
              done_next       = 1'b1;
              idx_next        = low_index;
              walk_level_next = 2'd1;
            end
            2'd1: begin
              done_next       = 1'b1;
              kind_next       = KIND_MAPPED;
              walk_level_next = 2'd0;
            end
            default: begin
              // stray returned word while idle
              done_next = 1'b0;
            end
          endcase
        end
        default: begin
          // pointer loads go to the pointer file, unused code does nothing
          done_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_level   <= '0;
      middle_index <= '0;
      low_index    <= '0;
      done         <= 1'b0;
    end else begin
      walk_level   <= walk_level_next;
      middle_index <= middle_index_next;
      low_index    <= low_index_next;
      done         <= done_next;
    end
  end

  // sector = partition start + block * sectors per block, wrapping; zero for an out-of-range result
  always_ff @(posedge clk) begin
    kind        <= kind_next;
    block_num   <= blk_next;
    entry_index <= idx_next;
    sector      <= zero_sector ? '0
                 : partition_start_sector + (blk_next << (l_eff + LOG_W'(1)));
  end

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> (kind == KIND_REQUEST || kind == KIND_MAPPED || kind == KIND_RANGE))
    else $error("illegal result kind");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (done && kind == KIND_RANGE) |->
      (block_num == '0 && entry_index == '0 && sector == '0))
    else $error("out of range result carries data");

  a_mapped_index: assert property (@(posedge clk) disable iff (rst)
    (done && kind == KIND_MAPPED) |-> (entry_index == '0 && walk_level == '0))
    else $error("mapped result leaves walk open or has index");

  a_request_walk: assert property (@(posedge clk) disable iff (rst)
    (done && kind == KIND_REQUEST) |-> (walk_level != '0))
    else $error("read request issued without pending walk");

  a_walk_steps: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.cmd == CMD_WORD && walk_level != '0) |=>
      (done && walk_level == $past(walk_level) - 2'd1))
    else $error("returned word did not advance walk by one level");

endmodule

// File: hdl/ext2_block_map_walker.sv
// top level: ext2 inode block map lookup with pointer-block read requests
//
// channels: an item is taken at a rising edge with start high and busy low;
// cmd selects a pointer load (pointer_slot, value), a map request (value is
// the logical block) or a returned pointer-block word (value). results leave
// on kind, block_num, entry_index and sector, marked by done for exactly
// one cycle; the receiver cannot stall, so every result is taken as shown.
// a map request gives a mapped block, an out-of-range status, or a read
// request; each returned word then gives the next request or the final block.
// configuration: cfg_we writes cfg_data to register cfg_index (0 block size code, 1
// partition start sector); the user must write only while no transaction is in flight, the block does not enforce it.
// throughput: one item per cycle; the input register feeds one pass of decode
// and the pointer file read into the result register, and the walk state is
// updated at that same edge, so a returned word may follow its request at once.
// reset: synchronous; clears the walk state, the result strobe and the
// configuration registers; busy is high while rst is high. inode pointers
// hold no value until loaded.
module ext2_block_map_walker
  import ebmw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [SLOT_W-1:0]  pointer_slot,
  input  logic [WORD_W-1:0]  value,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [WORD_W-1:0]  cfg_data,
  output logic               done,
  output logic [KIND_W-1:0]  kind,
  output logic [WORD_W-1:0]  block_num,
  output logic [INDEX_W-1:0] entry_index,
  output logic [WORD_W-1:0]  sector
);

  logic [LOG_W-1:0]  blk_size_code;
  logic [WORD_W-1:0] partition_start_sector;
  item_t             item;
  logic [WORD_W-1:0] direct_ptr, ptr_single, ptr_double, ptr_triple;

  assign busy = rst;

  always_ff @(posedge clk) begin
    item.cmd   <= cmd;
    item.slot  <= pointer_slot;
    item.value <= value;
    if (rst) begin
      blk_size_code          <= '0;
      partition_start_sector <= '0;
      item.valid             <= 1'b0;
    end else begin
      item.valid <= start;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BLK_SIZE:   blk_size_code          <= cfg_data[LOG_W-1:0];
          CFG_PART_START: partition_start_sector <= cfg_data;
          default:        blk_size_code          <= blk_size_code;
        endcase
      end
    end
  end

  ebmw_ptr_file u_ptr_file (
    .clk        (clk),
    .we         (item.valid && item.cmd == CMD_LOAD),
    .wr_slot    (item.slot),
    .wr_data    (item.value),
    .rd_slot    (item.value[SLOT_W-1:0]),
    .rd_data    (direct_ptr),
    .ptr_single (ptr_single),
    .ptr_double (ptr_double),
    .ptr_triple (ptr_triple)
  );

  ebmw_step u_step (
    .clk                    (clk),
    .rst                    (rst),
    .item                   (item),
    .blk_size_code          (blk_size_code),
    .partition_start_sector (partition_start_sector),
    .direct_ptr             (direct_ptr),
    .ptr_single             (ptr_single),
    .ptr_double             (ptr_double),
    .ptr_triple             (ptr_triple),
    .done                   (done),
    .kind                   (kind),
    .block_num              (block_num),
    .entry_index            (entry_index),
    .sector                 (sector)
  );

endmodule
